/* rtl/nnfd_pkg.sv */
// Shared types, constants and helpers of the nearest-neighbor frame downscaler.
package nnfd_pkg;

    localparam int DIM_BITS_DEFAULT = 11;
    localparam int REG_BITS = 11;
    localparam int PIX_BITS = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [REG_BITS-1:0] RESET_WIDTH = 11'd160;
    localparam logic [REG_BITS-1:0] RESET_HEIGHT = 11'd120;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SOURCE_WIDTH   = 2'd0,
        REG_SOURCE_HEIGHT  = 2'd1,
        REG_MAX_OUT_WIDTH  = 2'd2,
        REG_MAX_OUT_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                is_status;
        logic                frame_ok;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [REG_BITS-1:0] at_least_one(input logic [REG_BITS-1:0] v);
        return (v == '0) ? REG_BITS'(1) : v;
    endfunction

    function automatic logic [REG_BITS-1:0] min_dim(input logic [REG_BITS-1:0] a,
                                                    input logic [REG_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

/* rtl/nnfd_result_fifo.sv */
// Four-entry result queue that takes up to two results per cycle and delivers one while not stalled.
module nnfd_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  nnfd_pkg::push_t   push,
    output logic              space_ok,
    output nnfd_pkg::result_t head,
    output logic              head_valid,
    input  logic              head_stall
);

    localparam int DEPTH = nnfd_pkg::FIFO_DEPTH;
    localparam int PTR_BITS = nnfd_pkg::FIFO_PTR_BITS;
    localparam int CNT_BITS = nnfd_pkg::FIFO_CNT_BITS;

    nnfd_pkg::result_t mem [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] wr_ptr_plus1;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                pop;

    assign head_valid = (count_reg != '0);
    assign head = mem[rd_ptr_reg];
    assign pop = head_valid && !head_stall;
    assign space_ok = (count_reg <= CNT_BITS'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (count_reg <= CNT_BITS'(DEPTH - 2)))
        else $error("result queue written past its depth");

    a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_stall) |=> (head_valid && $stable(head)))
        else $error("stalled result changed or was lost");

endmodule

/* rtl/nearest_neighbor_frame_downscaler_unit.sv */
// Top level of the nearest-neighbor RGB565 frame downscaler with status output.
//
//   Channel   Signals                                      Direction
//   input     in_valid, in_stall, pixel_in, frame_end      source to block
//   output    out_valid, out_stall, pixel_out, is_status,  block to sink
//             frame_ok
//   config    cfg_write_en, cfg_index, cfg_data            host to block
//
// One input transaction is taken per unstalled cycle; its selection decision
// and counter updates settle in the same cycle and its zero, one or two
// results enter a four-entry queue, which delivers one result per cycle while
// out_stall is low; in_stall rises only while fewer than two entries are free.
// Reset clears all counters and sets sizes to 160x120 at once; no clearing pass.
module nearest_neighbor_frame_downscaler_unit #(
    parameter int DIM_BITS = nnfd_pkg::DIM_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [nnfd_pkg::PIX_BITS-1:0]        pixel_in,
    input  logic                                 frame_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [nnfd_pkg::PIX_BITS-1:0]        pixel_out,
    output logic                                 is_status,
    output logic                                 frame_ok,
    input  logic                                 cfg_write_en,
    input  logic [nnfd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [nnfd_pkg::REG_BITS-1:0]        cfg_data
);

    localparam int REG_BITS = nnfd_pkg::REG_BITS;
    localparam int ACC_BITS = 2 * DIM_BITS;
    localparam int CMP_BITS = ((DIM_BITS > REG_BITS) ? DIM_BITS : REG_BITS) + 1;
    localparam int SUM_BITS = ((ACC_BITS > REG_BITS) ? ACC_BITS : REG_BITS) + 1;

    logic [REG_BITS-1:0] source_width_reg;
    logic [REG_BITS-1:0] source_height_reg;
    logic [REG_BITS-1:0] max_out_width_reg;
    logic [REG_BITS-1:0] max_out_height_reg;

    logic [DIM_BITS-1:0] src_col_count_reg, src_col_count_next;
    logic [DIM_BITS-1:0] src_row_count_reg, src_row_count_next;
    logic [DIM_BITS-1:0] out_col_count_reg, out_col_count_next;
    logic [DIM_BITS-1:0] out_row_count_reg, out_row_count_next;
    logic [ACC_BITS-1:0] col_step_acc_reg, col_step_acc_next;
    logic [ACC_BITS-1:0] row_step_acc_reg, row_step_acc_next;
    logic                frame_full_reg, frame_full_next;

    logic [REG_BITS-1:0] w;
    logic [REG_BITS-1:0] h;
    logic [REG_BITS-1:0] dw;
    logic [REG_BITS-1:0] dh;
    logic                row_sel;
    logic                col_sel;
    logic                line_end;
    logic                last_row;
    logic [SUM_BITS-1:0] col_acc_add;
    logic [SUM_BITS-1:0] row_acc_add;
    logic [ACC_BITS-1:0] col_acc_inc;
    logic [ACC_BITS-1:0] row_acc_inc;
    logic [ACC_BITS-1:0] col_acc_dec;
    logic [ACC_BITS-1:0] row_acc_dec;
    logic                accept;
    logic                pixel_hit;
    logic                status_hit;
    logic                space_ok;
    nnfd_pkg::push_t     push;
    nnfd_pkg::result_t   pixel_item;
    nnfd_pkg::result_t   status_item;
    nnfd_pkg::result_t   head;

    assign accept = in_valid && !in_stall;
    assign in_stall = !space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg <= nnfd_pkg::RESET_WIDTH;
            source_height_reg <= nnfd_pkg::RESET_HEIGHT;
            max_out_width_reg <= nnfd_pkg::RESET_WIDTH;
            max_out_height_reg <= nnfd_pkg::RESET_HEIGHT;
        end
        else if (cfg_write_en)
        begin
            unique case (nnfd_pkg::cfg_reg_t'(cfg_index))
                nnfd_pkg::REG_SOURCE_WIDTH:   source_width_reg <= cfg_data;
                nnfd_pkg::REG_SOURCE_HEIGHT:  source_height_reg <= cfg_data;
                nnfd_pkg::REG_MAX_OUT_WIDTH:  max_out_width_reg <= cfg_data;
                nnfd_pkg::REG_MAX_OUT_HEIGHT: max_out_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w = nnfd_pkg::at_least_one(source_width_reg);
        h = nnfd_pkg::at_least_one(source_height_reg);
        dw = nnfd_pkg::min_dim(w, nnfd_pkg::at_least_one(max_out_width_reg));
        dh = nnfd_pkg::min_dim(h, nnfd_pkg::at_least_one(max_out_height_reg));

        row_sel = (CMP_BITS'(out_row_count_reg) < CMP_BITS'(dh))
                  && (SUM_BITS'(row_step_acc_reg) < SUM_BITS'(dh));
        col_sel = (CMP_BITS'(out_col_count_reg) < CMP_BITS'(dw))
                  && (SUM_BITS'(col_step_acc_reg) < SUM_BITS'(dw));

        col_acc_add = SUM_BITS'(col_step_acc_reg) + SUM_BITS'(w);
        row_acc_add = SUM_BITS'(row_step_acc_reg) + SUM_BITS'(h);
        col_acc_inc = col_sel ? col_acc_add[ACC_BITS-1:0] : col_step_acc_reg;
        row_acc_inc = row_sel ? row_acc_add[ACC_BITS-1:0] : row_step_acc_reg;
        col_acc_dec = (col_acc_inc >= ACC_BITS'(dw)) ? (col_acc_inc - ACC_BITS'(dw)) : '0;
        row_acc_dec = (row_acc_inc >= ACC_BITS'(dh)) ? (row_acc_inc - ACC_BITS'(dh)) : '0;

        line_end = (CMP_BITS'(src_col_count_reg) + CMP_BITS'(1)) >= CMP_BITS'(w);
        last_row = (CMP_BITS'(src_row_count_reg) + CMP_BITS'(1)) >= CMP_BITS'(h);

        src_col_count_next = src_col_count_reg;
        src_row_count_next = src_row_count_reg;
        out_col_count_next = out_col_count_reg;
        out_row_count_next = out_row_count_reg;
        col_step_acc_next = col_step_acc_reg;
        row_step_acc_next = row_step_acc_reg;
        frame_full_next = frame_full_reg;

        if (accept && !frame_full_reg)
        begin
            if (line_end)
            begin
                src_col_count_next = '0;
                out_col_count_next = '0;
                col_step_acc_next = '0;
                if (row_sel)
                begin
                    out_row_count_next = out_row_count_reg + DIM_BITS'(1);
                end
                row_step_acc_next = row_acc_dec;
                if (last_row)
                begin
                    frame_full_next = 1'b1;
                end
                else
                begin
                    src_row_count_next = src_row_count_reg + DIM_BITS'(1);
                end
            end
            else
            begin
                src_col_count_next = src_col_count_reg + DIM_BITS'(1);
                out_col_count_next = col_sel ? (out_col_count_reg + DIM_BITS'(1))
                                             : out_col_count_reg;
                col_step_acc_next = col_acc_dec;
            end
        end

        pixel_hit = accept && !frame_full_reg && row_sel && col_sel;
        status_hit = accept && frame_end;

        pixel_item.pixel = pixel_in;
        pixel_item.is_status = 1'b0;
        pixel_item.frame_ok = 1'b0;
        status_item.pixel = '0;
        status_item.is_status = 1'b1;
        status_item.frame_ok = frame_full_next;

        push.count = 2'(pixel_hit) + 2'(status_hit);
        push.first = pixel_hit ? pixel_item : status_item;
        push.second = status_item;

        if (status_hit)
        begin
            src_col_count_next = '0;
            src_row_count_next = '0;
            out_col_count_next = '0;
            out_row_count_next = '0;
            col_step_acc_next = '0;
            row_step_acc_next = '0;
            frame_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_count_reg <= '0;
            src_row_count_reg <= '0;
            out_col_count_reg <= '0;
            out_row_count_reg <= '0;
            col_step_acc_reg <= '0;
            row_step_acc_reg <= '0;
            frame_full_reg <= 1'b0;
        end
        else
        begin
            src_col_count_reg <= src_col_count_next;
            src_row_count_reg <= src_row_count_next;
            out_col_count_reg <= out_col_count_next;
            out_row_count_reg <= out_row_count_next;
            col_step_acc_reg <= col_step_acc_next;
            row_step_acc_reg <= row_step_acc_next;
            frame_full_reg <= frame_full_next;
        end
    end

    nnfd_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head       (head),
        .head_valid (out_valid),
        .head_stall (out_stall)
    );

    assign pixel_out = head.pixel;
    assign is_status = head.is_status;
    assign frame_ok = head.frame_ok;

    a_full_frame_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_full_reg && !frame_end) |-> (push.count == 2'd0))
        else $error("pixel passed after the frame was complete");

    a_restart_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> (src_col_count_reg == '0 && src_row_count_reg == '0
                                   && !frame_full_reg))
        else $error("counters not restarted after frame end");

    a_status_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_status) |-> (pixel_out == '0))
        else $error("status transaction carries a nonzero pixel");

endmodule
